FILE: sv/lln_pkg.sv
// shared types and constants for the pooled linked list engine
// no dependencies; every other file refers to this package by scoped names
`default_nettype none

package lln_pkg;

  localparam int POOL_NODES = 64;
  localparam int IDX_W      = $clog2(POOL_NODES);
  localparam int CNT_W      = $clog2(POOL_NODES + 1);
  localparam int VAL_W      = 32;
  localparam int OP_W       = 3;
  localparam int POS_W      = 8;
  localparam int STAT_W     = 3;
  // width that holds both a position and a count plus one without wrap
  localparam int CMP_W      = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

  typedef enum logic [OP_W-1:0] {
    OP_ADD_HEAD = 3'd0,
    OP_ADD_TAIL = 3'd1,
    OP_INSERT   = 3'd2,
    OP_REMOVE   = 3'd3,
    OP_LIST     = 3'd4,
    OP_CLEAR    = 3'd5
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE      = 3'd0,
    ST_FULL      = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_BAD_POS   = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK
  } state_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_ROTATE
  } cell_cmd_t;

  // broadcast to every cell of the row
  typedef struct packed {
    cell_cmd_t          cmd;
    logic [IDX_W-1:0]   at;
    logic               keep;
    logic [VAL_W-1:0]   din;
  } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: sv/lln_ifs.sv
// valid/ready channel interfaces for command and result beats
// depends on lln_pkg for field widths
`default_nettype none

interface lln_cmd_if;
  logic                              valid;
  logic                              ready;
  logic [lln_pkg::OP_W-1:0]          operation;
  logic signed [lln_pkg::VAL_W-1:0]  item_value;
  logic [lln_pkg::POS_W-1:0]         position;

  modport source (output valid, operation, item_value, position, input ready);
  modport sink (input valid, operation, item_value, position, output ready);
endinterface

interface lln_res_if;
  logic                              valid;
  logic                              ready;
  logic signed [lln_pkg::VAL_W-1:0]  out_value;
  logic [lln_pkg::STAT_W-1:0]        status;
  logic                              last_of_run;

  modport source (output valid, out_value, status, last_of_run, input ready);
  modport sink (input valid, out_value, status, last_of_run, output ready);
endinterface

`default_nettype wire

FILE: sv/lln_cell.sv
// one storage cell of the list row: holds one element, takes from a neighbor
// depends on lln_pkg for the broadcast control struct
`default_nettype none

module lln_cell (
  input  wire logic                        clk,
  input  wire lln_pkg::cell_ctrl_t         ctrl,
  input  wire logic [lln_pkg::IDX_W-1:0]   my_idx,
  input  wire logic [lln_pkg::VAL_W-1:0]   left,
  input  wire logic [lln_pkg::VAL_W-1:0]   right,
  output logic      [lln_pkg::VAL_W-1:0]   value
);

  always_ff @(posedge clk) begin
    unique case (ctrl.cmd)
      lln_pkg::CELL_INSERT: begin
        // open a gap at ctrl.at, everything behind moves one place back
        if (my_idx == ctrl.at) begin
          value <= ctrl.din;
        end else if (my_idx > ctrl.at) begin
          value <= left;
        end
      end
      lln_pkg::CELL_ROTATE: begin
        // head leaves the front and, if keep is set, is re-appended behind the last element
        if (ctrl.keep && (my_idx == ctrl.at)) begin
          value <= ctrl.din;
        end else begin
          value <= right;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: sv/pooled_linked_list_engine.sv
// top level of the pooled linked list engine: control sequencer and cell row
// depends on lln_pkg, lln_ifs (lln_cmd_if, lln_res_if) and lln_cell
`default_nettype none

//  channel | dir | beat payload                          | handshake
//  --------+-----+---------------------------------------+------------
//  cmd     | in  | operation, item_value, position       | valid/ready
//  res     | out | out_value, status, last_of_run        | valid/ready
//
//  add head, add tail, insert, clear and unused codes finish in the accepting cycle; the result
//  beat is loaded into the output register on the accepting edge.
//  remove and list out then rotate the cell row once, one element per cycle through cell 0;
//  both stall while res is held.
//  synchronous reset empties the list and the pool; cell contents are not reset.
//  a new command is taken while the previous result waits if res drains that cycle.

module pooled_linked_list_engine (
  input  wire logic   clk,
  input  wire logic   rst,
  lln_cmd_if.sink     cmd,
  lln_res_if.source   res
);

  // the list is kept in order in a row of cells: element k sits in cell k,
  // cells at or beyond cnt are don't care. used is the bump allocator,
  // which only clear and reset bring down, so the full flag follows the pool.

  lln_pkg::state_t                state, state_next;
  logic [lln_pkg::CNT_W-1:0]      cnt, cnt_next;
  logic [lln_pkg::CNT_W-1:0]      used, used_next;
  logic [lln_pkg::CNT_W-1:0]      rem, rem_next;
  lln_pkg::op_t                   walk_op, walk_op_next;
  logic [lln_pkg::VAL_W-1:0]      walk_val, walk_val_next;
  logic                           found, found_next;

  // output register
  logic                           ovalid, ovalid_next;
  logic [lln_pkg::VAL_W-1:0]      ovalue, ovalue_next;
  lln_pkg::status_t               ostatus, ostatus_next;
  logic                           olast, olast_next;

  logic                           cmd_ready;
  logic                           step_en;
  logic                           full;
  logic                           match;
  logic                           pos_bad;
  logic [lln_pkg::VAL_W-1:0]      head;
  logic [lln_pkg::CNT_W-1:0]      cnt_m1;
  logic [lln_pkg::POS_W-1:0]      pos_m1;
  lln_pkg::cell_ctrl_t            cell_ctrl;

  logic [lln_pkg::VAL_W-1:0]      cell_value [lln_pkg::POOL_NODES];

  // ---------------------------------------------------------------- cell row
  for (genvar i = 0; i < lln_pkg::POOL_NODES; i++) begin : g_cell
    logic [lln_pkg::VAL_W-1:0] left_v;
    logic [lln_pkg::VAL_W-1:0] right_v;

    if (i == 0) begin : g_first
      assign left_v = cell_value[i];
    end else begin : g_mid_l
      assign left_v = cell_value[i-1];
    end

    if (i == lln_pkg::POOL_NODES - 1) begin : g_last
      assign right_v = cell_value[i];
    end else begin : g_mid_r
      assign right_v = cell_value[i+1];
    end

    lln_cell u_cell (
      .clk    (clk),
      .ctrl   (cell_ctrl),
      .my_idx (lln_pkg::IDX_W'(i)),
      .left   (left_v),
      .right  (right_v),
      .value  (cell_value[i])
    );
  end

  // ---------------------------------------------------------------- control
  assign head    = cell_value[0];
  assign full    = (used >= lln_pkg::CNT_W'(lln_pkg::POOL_NODES));
  assign cnt_m1  = cnt - 1'b1;
  assign pos_m1  = cmd.position - 1'b1;
  // position zero, or beyond one past the end
  assign pos_bad = (cmd.position == '0) ||
                   (lln_pkg::CMP_W'(cmd.position) > (lln_pkg::CMP_W'(cnt) + 1'b1));
  assign match   = !found && (head == walk_val);

  assign cmd_ready = (state == lln_pkg::S_IDLE) && (!ovalid || res.ready);
  assign step_en   = (state == lln_pkg::S_WALK) && (!ovalid || res.ready);

  always_comb begin
    state_next    = state;
    cnt_next      = cnt;
    used_next     = used;
    rem_next      = rem;
    walk_op_next  = walk_op;
    walk_val_next = walk_val;
    found_next    = found;
    ovalid_next   = ovalid && !res.ready;
    ovalue_next   = ovalue;
    ostatus_next  = ostatus;
    olast_next    = olast;
    cell_ctrl     = '{cmd: lln_pkg::CELL_HOLD, at: '0, keep: 1'b0, din: '0};

    unique case (state)
      lln_pkg::S_IDLE: begin
        if (cmd.valid && cmd_ready) begin
          // default single result beat
          ovalid_next  = 1'b1;
          ovalue_next  = '0;
          ostatus_next = lln_pkg::ST_DONE;
          olast_next   = 1'b1;
          unique case (lln_pkg::op_t'(cmd.operation))
            lln_pkg::OP_ADD_HEAD: begin
              if (full) begin
                ostatus_next = lln_pkg::ST_FULL;
              end else begin
                cell_ctrl = '{cmd: lln_pkg::CELL_INSERT, at: '0, keep: 1'b0,
                              din: cmd.item_value};
                cnt_next  = cnt + 1'b1;
                used_next = used + 1'b1;
              end
            end
            lln_pkg::OP_ADD_TAIL: begin
              if (full) begin
                ostatus_next = lln_pkg::ST_FULL;
              end else begin
                cell_ctrl = '{cmd: lln_pkg::CELL_INSERT, at: cnt[lln_pkg::IDX_W-1:0],
                              keep: 1'b0, din: cmd.item_value};
                cnt_next  = cnt + 1'b1;
                used_next = used + 1'b1;
              end
            end
            lln_pkg::OP_INSERT: begin
              // range check ranks above the full check
              if (pos_bad) begin
                ostatus_next = lln_pkg::ST_BAD_POS;
              end else if (full) begin
                ostatus_next = lln_pkg::ST_FULL;
              end else begin
                cell_ctrl = '{cmd: lln_pkg::CELL_INSERT, at: pos_m1[lln_pkg::IDX_W-1:0],
                              keep: 1'b0, din: cmd.item_value};
                cnt_next  = cnt + 1'b1;
                used_next = used + 1'b1;
              end
            end
            lln_pkg::OP_REMOVE: begin
              if (cnt == '0) begin
                ostatus_next = lln_pkg::ST_EMPTY;
              end else begin
                ovalid_next   = ovalid && !res.ready;
                state_next    = lln_pkg::S_WALK;
                walk_op_next  = lln_pkg::OP_REMOVE;
                walk_val_next = cmd.item_value;
                rem_next      = cnt;
                found_next    = 1'b0;
              end
            end
            lln_pkg::OP_LIST: begin
              if (cnt == '0) begin
                ostatus_next = lln_pkg::ST_EMPTY;
              end else begin
                ovalid_next  = ovalid && !res.ready;
                state_next   = lln_pkg::S_WALK;
                walk_op_next = lln_pkg::OP_LIST;
                rem_next     = cnt;
                found_next   = 1'b0;
              end
            end
            lln_pkg::OP_CLEAR: begin
              cnt_next  = '0;
              used_next = '0;
            end
            default: begin
            end
          endcase
        end
      end

      lln_pkg::S_WALK: begin
        if (step_en) begin
          // head drops out of the row unless it is the first match on remove
          cell_ctrl = '{cmd: lln_pkg::CELL_ROTATE, at: cnt_m1[lln_pkg::IDX_W-1:0],
                        keep: (walk_op != lln_pkg::OP_REMOVE) || !match, din: head};
          rem_next  = rem - 1'b1;
          if (walk_op == lln_pkg::OP_REMOVE) begin
            if (match) begin
              found_next = 1'b1;
              cnt_next   = cnt - 1'b1;
            end
            if (rem == lln_pkg::CNT_W'(1)) begin
              ovalid_next  = 1'b1;
              ovalue_next  = '0;
              ostatus_next = (found || match) ? lln_pkg::ST_DONE : lln_pkg::ST_NOT_FOUND;
              olast_next   = 1'b1;
              state_next   = lln_pkg::S_IDLE;
            end
          end else begin
            ovalid_next  = 1'b1;
            ovalue_next  = head;
            ostatus_next = lln_pkg::ST_DONE;
            olast_next   = (rem == lln_pkg::CNT_W'(1));
            if (rem == lln_pkg::CNT_W'(1)) begin
              state_next = lln_pkg::S_IDLE;
            end
          end
        end
      end

      default: begin
        state_next = lln_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= lln_pkg::S_IDLE;
      cnt    <= '0;
      used   <= '0;
      rem    <= '0;
      found  <= 1'b0;
      ovalid <= 1'b0;
    end else begin
      state  <= state_next;
      cnt    <= cnt_next;
      used   <= used_next;
      rem    <= rem_next;
      found  <= found_next;
      ovalid <= ovalid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    walk_op  <= walk_op_next;
    walk_val <= walk_val_next;
    ovalue   <= ovalue_next;
    ostatus  <= ostatus_next;
    olast    <= olast_next;
  end

  assign cmd.ready       = cmd_ready;
  assign res.valid       = ovalid;
  assign res.out_value   = ovalue;
  assign res.status      = ostatus;
  assign res.last_of_run = olast;

  // ---------------------------------------------------------------- checks
  a_cnt_le_used: assert property (@(posedge clk) disable iff (rst)
    cnt <= used)
    else $error("list length exceeds allocated nodes");

  a_used_le_pool: assert property (@(posedge clk) disable iff (rst)
    used <= lln_pkg::CNT_W'(lln_pkg::POOL_NODES))
    else $error("allocator ran past the pool");

  a_walk_rem: assert property (@(posedge clk) disable iff (rst)
    (state == lln_pkg::S_WALK) |-> (rem != '0) && (rem <= cnt + {{(lln_pkg::CNT_W-1){1'b0}}, found}))
    else $error("walk step count out of range");

  a_list_keeps_len: assert property (@(posedge clk) disable iff (rst)
    (step_en && (walk_op == lln_pkg::OP_LIST)) |=> (cnt == $past(cnt)))
    else $error("list out changed the list length");

  a_no_ready_in_walk: assert property (@(posedge clk) disable iff (rst)
    (state == lln_pkg::S_WALK) |-> !cmd.ready)
    else $error("command taken during a walk");

endmodule

`default_nettype wire

FILE: test/tb_pooled_linked_list_engine.sv
`timescale 1ns / 100ps
// self-checking bench for pooled_linked_list_engine: directed and random list edits
// depends on lln_pkg and the lln_cmd_if / lln_res_if channel interfaces

module tb_pooled_linked_list_engine;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_ITEMS = 340;
  localparam int IDLE_PCT     = 27;
  // a full-pool list out walks every node; this covers it with margin
  localparam int SETTLE_CYCLES = 2 * lln_pkg::POOL_NODES + 16;

  // codes the block treats as no-ops
  localparam logic [lln_pkg::OP_W-1:0] OP_SPARE_A = 3'd6;
  localparam logic [lln_pkg::OP_W-1:0] OP_SPARE_B = 3'd7;

  // link code for "no node", one past the last pool slot
  localparam logic [lln_pkg::CNT_W-1:0] NO_NODE = lln_pkg::CNT_W'(lln_pkg::POOL_NODES);

  localparam logic signed [lln_pkg::VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [lln_pkg::VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  typedef struct {
    logic signed [lln_pkg::VAL_W-1:0] out_value;
    lln_pkg::status_t                 status;
    logic                             last_of_run;
  } list_beat_t;

  logic clk;
  logic rst;
  lln_cmd_if cmd_ch ();
  lln_res_if res_ch ();

  pooled_linked_list_engine dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .res (res_ch)
  );

  // shadow copy of the node pool; slot POOL_NODES is never written and only
  // keeps the arrays indexable by the full link code
  logic signed [lln_pkg::VAL_W-1:0] node_value [0:lln_pkg::POOL_NODES];
  logic [lln_pkg::CNT_W-1:0]        node_next  [0:lln_pkg::POOL_NODES];
  logic [lln_pkg::CNT_W-1:0]        head_node;
  logic [lln_pkg::CNT_W-1:0]        nodes_used;

  list_beat_t pending_results [$];
  int         mismatches;
  int         cycles;
  bit         steady;   // suppresses idling on both sides

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit: a hung handshake ends here
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  // result side back-pressure, roughly IDLE_PCT percent of cycles unless steady
  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      res_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // ---------------------------------------------------------------------------
  // list predictor
  // ---------------------------------------------------------------------------

  function automatic void expect_beat(input logic signed [lln_pkg::VAL_W-1:0] v,
                                      input lln_pkg::status_t st, input logic last);
    list_beat_t b;
    b.out_value   = v;
    b.status      = st;
    b.last_of_run = last;
    pending_results.push_back(b);
  endfunction

  // bump allocation: the next free slot, never reclaimed until clear
  function automatic logic [lln_pkg::CNT_W-1:0] take_node(
      input logic signed [lln_pkg::VAL_W-1:0] v, input logic [lln_pkg::CNT_W-1:0] link);
    logic [lln_pkg::CNT_W-1:0] idx;
    idx = nodes_used;
    node_value[idx] = v;
    node_next[idx]  = link;
    nodes_used      = nodes_used + 1'b1;
    return idx;
  endfunction

  function automatic int list_length();
    logic [lln_pkg::CNT_W-1:0] cur;
    int n;
    n   = 0;
    cur = head_node;
    while (cur != NO_NODE) begin
      cur = node_next[cur];
      n++;
    end
    return n;
  endfunction

  function automatic logic signed [lln_pkg::VAL_W-1:0] value_at(input int k);
    logic [lln_pkg::CNT_W-1:0] cur;
    cur = head_node;
    repeat (k) cur = node_next[cur];
    return node_value[cur];
  endfunction

  // apply one accepted command to the shadow list and queue the beats it causes
  task automatic predict_list_op(input logic [lln_pkg::OP_W-1:0] op,
                                 input logic signed [lln_pkg::VAL_W-1:0] v,
                                 input logic [lln_pkg::POS_W-1:0] p);
    logic [lln_pkg::CNT_W-1:0] cur;
    logic [lln_pkg::CNT_W-1:0] nxt;
    int unsigned               k;
    lln_pkg::status_t          st;
    bit                        full;
    st   = lln_pkg::ST_DONE;
    full = (nodes_used >= NO_NODE);
    case (op)
      lln_pkg::OP_ADD_HEAD: begin
        if (full) st = lln_pkg::ST_FULL;
        else head_node = take_node(v, head_node);
      end
      lln_pkg::OP_ADD_TAIL: begin
        if (full) st = lln_pkg::ST_FULL;
        else if (head_node == NO_NODE) head_node = take_node(v, NO_NODE);
        else begin
          cur = head_node;
          while (node_next[cur] != NO_NODE) cur = node_next[cur];
          node_next[cur] = take_node(v, NO_NODE);
        end
      end
      lln_pkg::OP_INSERT: begin
        if (p == '0) st = lln_pkg::ST_BAD_POS;
        else if (p == lln_pkg::POS_W'(1)) begin
          if (full) st = lln_pkg::ST_FULL;
          else head_node = take_node(v, head_node);
        end else begin
          // stop on the node that the new one follows
          cur = head_node;
          k   = 1;
          while (cur != NO_NODE && k < p - 1) begin
            cur = node_next[cur];
            k++;
          end
          // range check wins over the full check
          if (cur == NO_NODE) st = lln_pkg::ST_BAD_POS;
          else if (full) st = lln_pkg::ST_FULL;
          else node_next[cur] = take_node(v, node_next[cur]);
        end
      end
      lln_pkg::OP_REMOVE: begin
        if (head_node == NO_NODE) st = lln_pkg::ST_EMPTY;
        else if (node_value[head_node] == v) head_node = node_next[head_node];
        else begin
          st  = lln_pkg::ST_NOT_FOUND;
          cur = head_node;
          nxt = node_next[cur];
          while (nxt != NO_NODE && st == lln_pkg::ST_NOT_FOUND) begin
            if (node_value[nxt] == v) begin
              node_next[cur] = node_next[nxt];
              st = lln_pkg::ST_DONE;
            end else begin
              cur = nxt;
              nxt = node_next[cur];
            end
          end
        end
      end
      lln_pkg::OP_LIST: begin
        if (head_node == NO_NODE) st = lln_pkg::ST_EMPTY;
        else begin
          // one beat per element, last mark on the tail
          cur = head_node;
          while (cur != NO_NODE) begin
            nxt = node_next[cur];
            expect_beat(node_value[cur], lln_pkg::ST_DONE, nxt == NO_NODE);
            cur = nxt;
          end
          return;
        end
      end
      lln_pkg::OP_CLEAR: begin
        head_node  = NO_NODE;
        nodes_used = '0;
      end
      default: ;  // spare codes answer done and touch nothing
    endcase
    expect_beat('0, st, 1'b1);
  endtask

  // ---------------------------------------------------------------------------
  // command side
  // ---------------------------------------------------------------------------

  // drive one command beat and wait for it to be taken; valid stays high on
  // return so back-to-back beats need no dead cycle
  task automatic issue_command(input logic [lln_pkg::OP_W-1:0] op,
                               input logic signed [lln_pkg::VAL_W-1:0] v,
                               input logic [lln_pkg::POS_W-1:0] p);
    if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      cmd_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < IDLE_PCT);
    end
    cmd_ch.valid      <= 1'b1;
    cmd_ch.operation  <= op;
    cmd_ch.item_value <= v;
    cmd_ch.position   <= p;
    do @(posedge clk); while (cmd_ch.ready !== 1'b1);
    predict_list_op(op, v, p);
  endtask

  // drop valid and hold off until every queued beat has come back
  task automatic wait_drain();
    cmd_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // result checker: each accepted beat against the oldest expectation
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    list_beat_t want;
    if (!rst && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: value %0d status %0d last %0b",
                   res_ch.out_value, res_ch.status, res_ch.last_of_run);
      end else begin
        want = pending_results.pop_front();
        if (res_ch.out_value !== want.out_value || res_ch.status !== want.status ||
            res_ch.last_of_run !== want.last_of_run) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected value %0d status %0d last %0b, got %0d %0d %0b",
                     want.out_value, want.status, want.last_of_run,
                     res_ch.out_value, res_ch.status, res_ch.last_of_run);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // list, remove and bad-position inserts on the empty list right after reset
  task automatic test_empty_list();
    issue_command(lln_pkg::OP_LIST, '0, '0);             // list empty, single beat
    issue_command(lln_pkg::OP_REMOVE, 32'sd5, '0);       // remove on empty list
    issue_command(lln_pkg::OP_INSERT, 32'sd9, 8'd0);     // position zero
    issue_command(lln_pkg::OP_INSERT, 32'sd9, 8'd2);     // past the end of empty list
    wait_drain();
  endtask

  // field extremes through head, tail and positional inserts
  task automatic test_edits_and_extremes();
    issue_command(lln_pkg::OP_INSERT, VAL_MIN, 8'd1);        // position one acts as add head
    issue_command(lln_pkg::OP_ADD_TAIL, VAL_MAX, 8'd255);
    issue_command(lln_pkg::OP_ADD_HEAD, 32'sd0, '0);
    issue_command(lln_pkg::OP_ADD_TAIL, -32'sd1, '0);
    issue_command(lln_pkg::OP_INSERT, 32'sh5555_5555, 8'd5); // length plus one appends
    issue_command(lln_pkg::OP_INSERT, 32'sh2aaa_aaaa, 8'd7); // one beyond that is rejected
    issue_command(lln_pkg::OP_INSERT, 32'shaaaa_aaaa, 8'd3); // middle of the list
    issue_command(lln_pkg::OP_INSERT, 32'sd1, 8'd255);
    issue_command(lln_pkg::OP_LIST, '0, '0);
    wait_drain();
  endtask

  // head, middle, tail and missing values; duplicates remove the first only
  task automatic test_removal();
    issue_command(lln_pkg::OP_ADD_TAIL, VAL_MAX, '0);         // duplicate of an earlier entry
    issue_command(lln_pkg::OP_REMOVE, 32'sd0, '0);            // head
    issue_command(lln_pkg::OP_REMOVE, 32'shaaaa_aaaa, '0);    // middle
    issue_command(lln_pkg::OP_REMOVE, VAL_MAX, '0);           // first of two copies
    issue_command(lln_pkg::OP_REMOVE, 32'sd12345, '0);        // not present
    issue_command(lln_pkg::OP_LIST, '0, '0);
    issue_command(lln_pkg::OP_REMOVE, VAL_MAX, '0);           // now the tail
    issue_command(lln_pkg::OP_LIST, '0, '0);
    wait_drain();
  endtask

  // spare codes are no-ops; clear empties the list and the pool
  task automatic test_spare_codes_and_clear();
    issue_command(OP_SPARE_A, VAL_MAX, 8'd255);
    issue_command(OP_SPARE_B, VAL_MIN, 8'd0);
    issue_command(lln_pkg::OP_LIST, '0, '0);
    issue_command(lln_pkg::OP_CLEAR, '0, '0);
    issue_command(lln_pkg::OP_LIST, '0, '0);
    issue_command(lln_pkg::OP_ADD_TAIL, 32'sd77, '0);
    issue_command(lln_pkg::OP_LIST, '0, '0);
    wait_drain();
  endtask

  // fill every slot, then hit each full and range case at the limit
  task automatic test_pool_exhaustion();
    int i;
    int len;
    issue_command(lln_pkg::OP_CLEAR, '0, '0);
    for (i = 0; i < lln_pkg::POOL_NODES; i++) begin
      len = list_length();
      case ($urandom_range(0, 2))
        0:       issue_command(lln_pkg::OP_ADD_HEAD, $urandom, '0);
        1:       issue_command(lln_pkg::OP_ADD_TAIL, $urandom, '0);
        default: issue_command(lln_pkg::OP_INSERT, $urandom,
                               lln_pkg::POS_W'($urandom_range(1, len + 1)));
      endcase
    end
    len = list_length();
    issue_command(lln_pkg::OP_ADD_HEAD, 32'sd1, '0);
    issue_command(lln_pkg::OP_ADD_TAIL, 32'sd2, '0);
    issue_command(lln_pkg::OP_INSERT, 32'sd3, 8'd1);
    issue_command(lln_pkg::OP_INSERT, 32'sd4, 8'd2);
    issue_command(lln_pkg::OP_INSERT, 32'sd5, lln_pkg::POS_W'(len + 1));
    // range check before full check
    issue_command(lln_pkg::OP_INSERT, 32'sd6, lln_pkg::POS_W'(len + 2));
    // unlinked nodes stay spent
    issue_command(lln_pkg::OP_REMOVE, value_at(len / 2), '0);
    issue_command(lln_pkg::OP_ADD_TAIL, 32'sd7, '0);
    issue_command(lln_pkg::OP_LIST, '0, '0);
    issue_command(lln_pkg::OP_CLEAR, '0, '0);
    issue_command(lln_pkg::OP_ADD_HEAD, 32'sd8, '0);
    issue_command(lln_pkg::OP_LIST, '0, '0);
    wait_drain();
  endtask

  function automatic logic signed [lln_pkg::VAL_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    // narrow values give duplicates and removable hits
    if (r < 30) return lln_pkg::VAL_W'($urandom_range(0, 7));
    if (r < 34) return VAL_MIN;
    if (r < 38) return VAL_MAX;
    if (r < 42) return -32'sd1;
    return $urandom;
  endfunction

  // sessions that start from a clear and grow the list, now and then to a
  // full pool; most removes aim at live values so the walk reaches deep
  task automatic test_random_sessions();
    int placed;
    int session;
    int span;
    int len;
    int unsigned r;
    int unsigned rp;
    logic signed [lln_pkg::VAL_W-1:0] v;
    logic [lln_pkg::POS_W-1:0] p;
    placed  = 0;
    session = 0;
    while (placed < RANDOM_ITEMS) begin
      steady = (session == 2);  // one long stretch with no idling on either side
      // sender holds off until the engine has answered everything
      if (session == 1 || $urandom_range(0, 5) == 0) wait_drain();
      issue_command(lln_pkg::OP_CLEAR, $urandom, lln_pkg::POS_W'($urandom_range(0, 255)));
      placed++;
      span = steady ? 120 : $urandom_range(5, 120);
      repeat (span) begin
        len = list_length();
        r   = $urandom_range(0, 99);
        rp  = $urandom_range(0, 99);
        v   = pick_value();
        if (rp < 8) p = '0;
        else if (rp < 18) p = lln_pkg::POS_W'($urandom_range(0, 255));
        else p = lln_pkg::POS_W'($urandom_range(1, len + 2));
        if (r < 22) issue_command(lln_pkg::OP_ADD_HEAD, v, p);
        else if (r < 44) issue_command(lln_pkg::OP_ADD_TAIL, v, p);
        else if (r < 64) issue_command(lln_pkg::OP_INSERT, v, p);
        else if (r < 80) begin
          if (len > 0 && $urandom_range(0, 9) < 7)
            v = value_at($urandom_range(0, len - 1));
          issue_command(lln_pkg::OP_REMOVE, v, p);
        end else if (r < 92) issue_command(lln_pkg::OP_LIST, v, p);
        else if (r < 95) issue_command(lln_pkg::OP_CLEAR, v, p);
        if (r < 95) placed++;
        else issue_command($urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B, v, p);
      end
      session++;
    end
    steady = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    mismatches = 0;
    steady     = 1'b0;
    head_node  = NO_NODE;
    nodes_used = '0;
    rst               <= 1'b1;
    cmd_ch.valid      <= 1'b0;
    cmd_ch.operation  <= lln_pkg::OP_ADD_HEAD;
    cmd_ch.item_value <= '0;
    cmd_ch.position   <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_empty_list();
    test_edits_and_extremes();
    test_removal();
    test_spare_codes_and_clear();
    test_pool_exhaustion();
    test_random_sessions();

    wait_drain();
    // catch any stray beat after the last expected one
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

FILE: pooled_linked_list_engine.f
sv/lln_pkg.sv
sv/lln_ifs.sv
sv/lln_cell.sv
sv/pooled_linked_list_engine.sv
test/tb_pooled_linked_list_engine.sv
